/* design/lattice_boltzmann_equilibrium_macros.svh */
// Assertion macros for the lattice Boltzmann equilibrium block
`ifndef LATTICE_BOLTZMANN_EQUILIBRIUM_MACROS_SVH
`define LATTICE_BOLTZMANN_EQUILIBRIUM_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LBE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LBE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/lbe_pkg.sv */
// Types, constants and direction tables for the lattice Boltzmann equilibrium block
package lbe_pkg;

  localparam int VEL_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF = 27;

  localparam int VEL_W   = 18;
  localparam int DENS_W  = 24;
  localparam int DIR_W   = 5;
  localparam int POP_W   = 32;
  localparam int WT_W    = 7;
  localparam int SUM_W   = 20;
  localparam int SQ_W    = 35;
  localparam int SSQ_W   = 38;
  localparam int UU_W    = 36;
  localparam int CLAMP_W = 36;
  localparam int SPLIT_W = 18;
  localparam int QH_W    = 14;
  localparam int REM_W   = 5;
  localparam int Y_W     = REM_W + SPLIT_W;
  localparam int QL_W    = 19;
  localparam int Q_W     = 32;

  localparam int DIV_D       = 27;
  localparam int DIV_RECIP_W = 26;
  localparam int DIV_SHIFT   = 30;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 26'd39768215;

  localparam logic [Q_W-1:0] POP_MAX_MAG = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] POP_MIN_MAG = 32'h8000_0000;
  localparam logic [POP_W-1:0] POP_MAX = 32'h7FFF_FFFF;
  localparam logic [POP_W-1:0] POP_MIN = 32'h8000_0000;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_LATTICE_SELECT,
    REG_LINEAR_ONLY
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LAT_D2Q9,
    LAT_D3Q15,
    LAT_D3Q19,
    LAT_D3Q27
  } lattice_t;

  typedef struct packed {
    logic signed [1:0] cx;
    logic signed [1:0] cy;
    logic signed [1:0] cz;
    logic [WT_W-1:0]   wt;
  } dir_entry_t;

  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             last;
    logic             lin;
    logic             neg;
  } tag_t;

  function automatic dir_entry_t mk_dir(int cx, int cy, int cz, int wt);
    dir_entry_t e;
    e.cx = 2'(cx);
    e.cy = 2'(cy);
    e.cz = 2'(cz);
    e.wt = WT_W'(wt);
    return e;
  endfunction

  localparam dir_entry_t D2Q9_TAB [9] = '{
    mk_dir(0, 0, 0, 96), mk_dir(1, 0, 0, 24), mk_dir(1, 1, 0, 6),
    mk_dir(0, 1, 0, 24), mk_dir(-1, 1, 0, 6), mk_dir(-1, 0, 0, 24),
    mk_dir(-1, -1, 0, 6), mk_dir(0, -1, 0, 24), mk_dir(1, -1, 0, 6)
  };

  localparam dir_entry_t D3Q15_TAB [15] = '{
    mk_dir(0, 0, 0, 48), mk_dir(1, 0, 0, 24), mk_dir(0, 1, 0, 24),
    mk_dir(-1, 0, 0, 24), mk_dir(0, -1, 0, 24), mk_dir(0, 0, -1, 24),
    mk_dir(1, 1, -1, 3), mk_dir(-1, 1, -1, 3), mk_dir(-1, -1, -1, 3),
    mk_dir(1, -1, -1, 3), mk_dir(0, 0, 1, 24), mk_dir(1, 1, 1, 3),
    mk_dir(-1, 1, 1, 3), mk_dir(-1, -1, 1, 3), mk_dir(1, -1, 1, 3)
  };

  localparam dir_entry_t D3Q19_TAB [19] = '{
    mk_dir(0, 0, 0, 72), mk_dir(1, 0, 0, 12), mk_dir(1, 1, 0, 6),
    mk_dir(0, 1, 0, 12), mk_dir(-1, 1, 0, 6), mk_dir(-1, 0, 0, 12),
    mk_dir(-1, -1, 0, 6), mk_dir(0, -1, 0, 12), mk_dir(1, -1, 0, 6),
    mk_dir(0, 0, -1, 12), mk_dir(1, 0, -1, 6), mk_dir(0, 1, -1, 6),
    mk_dir(-1, 0, -1, 6), mk_dir(0, -1, -1, 6), mk_dir(0, 0, 1, 12),
    mk_dir(1, 0, 1, 6), mk_dir(0, 1, 1, 6), mk_dir(-1, 0, 1, 6),
    mk_dir(0, -1, 1, 6)
  };

  localparam dir_entry_t D3Q27_TAB [27] = '{
    mk_dir(0, 0, 0, 64), mk_dir(1, 0, 0, 16), mk_dir(1, 1, 0, 4),
    mk_dir(0, 1, 0, 16), mk_dir(-1, 1, 0, 4), mk_dir(-1, 0, 0, 16),
    mk_dir(-1, -1, 0, 4), mk_dir(0, -1, 0, 16), mk_dir(1, -1, 0, 4),
    mk_dir(0, 0, -1, 16), mk_dir(1, 0, -1, 4), mk_dir(1, 1, -1, 1),
    mk_dir(0, 1, -1, 4), mk_dir(-1, 1, -1, 1), mk_dir(-1, 0, -1, 4),
    mk_dir(-1, -1, -1, 1), mk_dir(0, -1, -1, 4), mk_dir(1, -1, -1, 1),
    mk_dir(0, 0, 1, 16), mk_dir(1, 0, 1, 4), mk_dir(1, 1, 1, 1),
    mk_dir(0, 1, 1, 4), mk_dir(-1, 1, 1, 1), mk_dir(-1, 0, 1, 4),
    mk_dir(-1, -1, 1, 1), mk_dir(0, -1, 1, 4), mk_dir(1, -1, 1, 1)
  };

  function automatic dir_entry_t lat_lookup(lattice_t sel, logic [DIR_W-1:0] dir);
    dir_entry_t e;
    unique case (sel)
      LAT_D2Q9:  e = D2Q9_TAB[dir[3:0]];
      LAT_D3Q15: e = D3Q15_TAB[dir[3:0]];
      LAT_D3Q19: e = D3Q19_TAB[dir];
      LAT_D3Q27: e = D3Q27_TAB[dir];
    endcase
    return e;
  endfunction

  function automatic logic [DIR_W-1:0] lat_last(lattice_t sel);
    logic [DIR_W-1:0] n;
    unique case (sel)
      LAT_D2Q9:  n = DIR_W'(8);
      LAT_D3Q15: n = DIR_W'(14);
      LAT_D3Q19: n = DIR_W'(18);
      LAT_D3Q27: n = DIR_W'(26);
    endcase
    return n;
  endfunction

  // velocity component weighted by a lattice coordinate of -1, 0 or +1
  function automatic logic signed [SUM_W-1:0] c_term(logic signed [1:0] c,
                                                     logic signed [VEL_W-1:0] u);
    logic signed [SUM_W-1:0] r;
    priority if (c == 2'sd1) begin
      r = SUM_W'(u);
    end else if (c == -2'sd1) begin
      r = -SUM_W'(u);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

/* design/lattice_boltzmann_equilibrium.sv */
// Lattice Boltzmann BGK equilibrium generator: direction sequencer and arithmetic pipeline
//
// Usage:
//  - Input channel (in_valid / in_stall) takes one node: velocity in_vel_x/y/z
//    (signed, VELOCITY_FRAC_BITS fraction bits) and in_density (unsigned Q4.20).
//  - Output channel (out_valid / out_stall) returns one population per direction
//    of the selected lattice, directions in order, out_last on the final one.
//  - Registers over the APB-style port: lattice_select at 0x0, linear_only at 0x4.
//    The node takes the register values present when it is accepted.
//  - Throughput: one population per cycle while the output is not stalled; a node
//    gives Q populations (Q = 9, 15, 19 or 27), as the direction sequencer issues
//    one direction a cycle. The next node is accepted on the cycle its predecessor's
//    last direction issues.
//  - Pipeline: the arithmetic pipeline holds 11 stages plus the output register.
//  - Reset (rst_n low, synchronous) empties the pipeline and sets both registers
//    to zero (D2Q9, full second order equilibrium).
//  - While the output is valid and stalled, every stage holds; in_stall rises
//    once the sequencer has a node in flight.
`include "lattice_boltzmann_equilibrium_macros.svh"

module lattice_boltzmann_equilibrium #(
  parameter int VELOCITY_FRAC_BITS = lbe_pkg::VEL_FRAC_BITS_DEF,
  parameter int OUTPUT_FRAC_BITS   = lbe_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lbe_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [lbe_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [lbe_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [lbe_pkg::VEL_W-1:0]      in_vel_x,
  input  logic signed [lbe_pkg::VEL_W-1:0]      in_vel_y,
  input  logic signed [lbe_pkg::VEL_W-1:0]      in_vel_z,
  input  logic [lbe_pkg::DENS_W-1:0]            in_density,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lbe_pkg::DIR_W-1:0]             out_direction,
  output logic signed [lbe_pkg::POP_W-1:0]      out_population,
  output logic                                  out_last
);

  localparam int V       = VELOCITY_FRAC_BITS;
  localparam int TW_A    = 2 * V + 3;
  localparam int TW_B    = V + 24;
  localparam int TW_AB   = (TW_A > TW_B) ? TW_A : TW_B;
  localparam int T_W     = (TW_AB > 44) ? TW_AB : 44;
  localparam int MAG_W   = T_W - 1;
  localparam int DN_W    = lbe_pkg::DENS_W + lbe_pkg::WT_W;
  localparam int CHUNK_W = 32;
  localparam int N_CHUNK = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int PP_W    = CHUNK_W + DN_W;
  localparam int PROD_W  = MAG_W + DN_W;
  localparam int SHIFT_K = 2 * V + 24 - OUTPUT_FRAC_BITS;
  localparam int N_STG   = 11;
  localparam int HM_W    = lbe_pkg::SPLIT_W + lbe_pkg::DIV_RECIP_W;
  localparam int YM_W    = lbe_pkg::Y_W + lbe_pkg::DIV_RECIP_W;

  // configuration registers
  lbe_pkg::lattice_t lat_sel_r;
  logic              lin_only_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_sel_r  <= lbe_pkg::LAT_D2Q9;
      lin_only_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (lbe_pkg::cfg_reg_t'(paddr[2]))
        lbe_pkg::REG_LATTICE_SELECT: lat_sel_r  <= lbe_pkg::lattice_t'(pwdata[1:0]);
        lbe_pkg::REG_LINEAR_ONLY:    lin_only_r <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (lbe_pkg::cfg_reg_t'(paddr[2]))
      lbe_pkg::REG_LATTICE_SELECT: prdata = lbe_pkg::CFG_DATA_W'(lat_sel_r);
      lbe_pkg::REG_LINEAR_ONLY:    prdata = lbe_pkg::CFG_DATA_W'(lin_only_r);
    endcase
  end

  // direction sequencer
  logic                              adv;
  logic                              at_last;
  logic                              in_acc;
  logic                              issue;
  logic                              busy_r;
  logic [lbe_pkg::DIR_W-1:0]         dir_r;
  logic [lbe_pkg::DIR_W-1:0]         last_dir_r;
  lbe_pkg::lattice_t                 node_sel_r;
  logic                              node_lin_r;
  logic signed [lbe_pkg::VEL_W-1:0]  ux_r;
  logic signed [lbe_pkg::VEL_W-1:0]  uy_r;
  logic signed [lbe_pkg::VEL_W-1:0]  uz_r;
  logic [lbe_pkg::DENS_W-1:0]        dens_r;
  lbe_pkg::dir_entry_t               ent;
  logic                              out_valid_r;

  assign adv      = !(out_valid_r && out_stall);
  assign at_last  = (dir_r == last_dir_r);
  assign in_stall = busy_r && !(adv && at_last);
  assign in_acc   = in_valid && !in_stall;
  assign issue    = busy_r && adv;
  assign ent      = lbe_pkg::lat_lookup(node_sel_r, dir_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dir_r  <= '0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
      dir_r  <= '0;
    end else if (issue) begin
      busy_r <= !at_last;
      dir_r  <= dir_r + lbe_pkg::DIR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      node_sel_r <= lat_sel_r;
      last_dir_r <= lbe_pkg::lat_last(lat_sel_r);
      node_lin_r <= lin_only_r;
      ux_r       <= in_vel_x;
      uy_r       <= in_vel_y;
      uz_r       <= (lat_sel_r == lbe_pkg::LAT_D2Q9) ? '0 : in_vel_z;
      dens_r     <= in_density;
    end
  end

  // valid bits and tags travel with the data
  logic          vld_r   [N_STG];
  logic          vld_nxt [N_STG];
  lbe_pkg::tag_t tag_r   [N_STG];
  lbe_pkg::tag_t tag_nxt [N_STG];

  // stage registers
  logic signed [lbe_pkg::SUM_W-1:0] s1_r, s1_nxt;
  logic [lbe_pkg::SQ_W-1:0]         sqx_r, sqx_nxt, sqy_r, sqy_nxt, sqz_r, sqz_nxt;
  logic [DN_W-1:0]                  dn1_r, dn1_nxt, dn2_r, dn3_r, dn4_r;
  logic signed [lbe_pkg::SUM_W-1:0] s2_r;
  logic [lbe_pkg::SSQ_W-1:0]        ssq2_r, ssq2_nxt;
  logic [lbe_pkg::UU_W-1:0]         uu2_r, uu2_nxt;
  logic [T_W-1:0]                   t3_r, t3_nxt;
  logic [MAG_W-1:0]                 mag4_r, mag4_nxt;
  logic [PP_W-1:0]                  pp5_r [N_CHUNK];
  logic [PP_W-1:0]                  pp5_nxt [N_CHUNK];
  logic [PROD_W-1:0]                prod6_r, prod6_nxt;
  logic [lbe_pkg::CLAMP_W-1:0]      x7_r, x7_nxt;
  logic [lbe_pkg::QH_W-1:0]         qh8_r, qh8_nxt, qh9_r, qh9_nxt, qh10_r;
  logic [lbe_pkg::SPLIT_W-1:0]      h8_r, l8_r;
  logic [lbe_pkg::Y_W-1:0]          y9_r, y9_nxt, y10_r;
  logic [lbe_pkg::QL_W-1:0]         ql10_r, ql10_nxt;
  logic [lbe_pkg::Q_W-1:0]          q11_r, q11_nxt;

  // stage 1: projection c.u, velocity squares, density times weight
  logic signed [2*lbe_pkg::VEL_W-1:0] px, py, pz;

  always_comb begin
    s1_nxt  = lbe_pkg::c_term(ent.cx, ux_r) + lbe_pkg::c_term(ent.cy, uy_r)
            + lbe_pkg::c_term(ent.cz, uz_r);
    px      = (2*lbe_pkg::VEL_W)'(ux_r) * (2*lbe_pkg::VEL_W)'(ux_r);
    py      = (2*lbe_pkg::VEL_W)'(uy_r) * (2*lbe_pkg::VEL_W)'(uy_r);
    pz      = (2*lbe_pkg::VEL_W)'(uz_r) * (2*lbe_pkg::VEL_W)'(uz_r);
    sqx_nxt = px[lbe_pkg::SQ_W-1:0];
    sqy_nxt = py[lbe_pkg::SQ_W-1:0];
    sqz_nxt = pz[lbe_pkg::SQ_W-1:0];
    dn1_nxt = DN_W'(dens_r) * DN_W'(ent.wt);
  end

  // stage 2: (c.u)^2 and u.u
  logic signed [2*lbe_pkg::SUM_W-1:0] sp;

  always_comb begin
    sp       = (2*lbe_pkg::SUM_W)'(s1_r) * (2*lbe_pkg::SUM_W)'(s1_r);
    ssq2_nxt = sp[lbe_pkg::SSQ_W-1:0];
    uu2_nxt  = lbe_pkg::UU_W'(sqx_r) + lbe_pkg::UU_W'(sqy_r) + lbe_pkg::UU_W'(sqz_r);
  end

  // stage 3: bracket term T
  logic [T_W-1:0] one_t, sx, ssq_e, uu_e, t_lin, t_quad;

  always_comb begin
    one_t  = T_W'(1) << (2 * V + 1);
    sx     = T_W'(s2_r);
    ssq_e  = T_W'(ssq2_r);
    uu_e   = T_W'(uu2_r);
    t_lin  = one_t + (sx << (V + 2)) + (sx << (V + 1));
    t_quad = (ssq_e << 3) + ssq_e - (uu_e << 1) - uu_e;
    t3_nxt = tag_r[1].lin ? t_lin : t_lin + t_quad;
  end

  // stage 4: sign and magnitude
  logic [T_W-1:0] t_abs;

  always_comb begin
    t_abs    = t3_r[T_W-1] ? (T_W'(0) - t3_r) : t3_r;
    mag4_nxt = t_abs[MAG_W-1:0];
  end

  // stage 5: partial products of |T| and density*weight
  logic [N_CHUNK*CHUNK_W-1:0] magp;

  assign magp = (N_CHUNK*CHUNK_W)'(mag4_r);

  always_comb begin
    for (int j = 0; j < N_CHUNK; j++) begin
      pp5_nxt[j] = PP_W'(magp[j*CHUNK_W +: CHUNK_W]) * PP_W'(dn4_r);
    end
  end

  // stage 6: sum partial products
  always_comb begin
    prod6_nxt = '0;
    for (int j = 0; j < N_CHUNK; j++) begin
      prod6_nxt = prod6_nxt + (PROD_W'(pp5_r[j]) << (j * CHUNK_W));
    end
  end

  // stage 7: scale and clamp to the range that can still fit after division
  logic [PROD_W-1:0] sh;

  always_comb begin
    sh     = prod6_r >> SHIFT_K;
    x7_nxt = (|sh[PROD_W-1:lbe_pkg::CLAMP_W]) ? '1 : sh[lbe_pkg::CLAMP_W-1:0];
  end

  // stage 8: estimate upper quotient digit of x / 27
  logic [HM_W-1:0] hm;

  always_comb begin
    hm      = HM_W'(x7_r[lbe_pkg::CLAMP_W-1:lbe_pkg::SPLIT_W]) * HM_W'(lbe_pkg::DIV_RECIP);
    qh8_nxt = hm[lbe_pkg::DIV_SHIFT +: lbe_pkg::QH_W];
  end

  // stage 9: correct upper digit, form lower dividend
  logic [lbe_pkg::SPLIT_W-1:0] h27, rh_raw, rh;
  logic                        fix_h;

  always_comb begin
    h27     = (lbe_pkg::SPLIT_W'(qh8_r) << 4) + (lbe_pkg::SPLIT_W'(qh8_r) << 3)
            + (lbe_pkg::SPLIT_W'(qh8_r) << 1) + lbe_pkg::SPLIT_W'(qh8_r);
    rh_raw  = h8_r - h27;
    fix_h   = rh_raw >= lbe_pkg::SPLIT_W'(lbe_pkg::DIV_D);
    rh      = fix_h ? rh_raw - lbe_pkg::SPLIT_W'(lbe_pkg::DIV_D) : rh_raw;
    qh9_nxt = qh8_r + lbe_pkg::QH_W'(fix_h);
    y9_nxt  = {rh[lbe_pkg::REM_W-1:0], l8_r};
  end

  // stage 10: estimate lower quotient
  logic [YM_W-1:0] ym;

  always_comb begin
    ym       = YM_W'(y9_r) * YM_W'(lbe_pkg::DIV_RECIP);
    ql10_nxt = ym[lbe_pkg::DIV_SHIFT +: lbe_pkg::QL_W];
  end

  // stage 11: correct lower quotient, assemble |population|
  logic [lbe_pkg::Y_W-1:0] y27, ry_raw;
  logic                    fix_l;

  always_comb begin
    y27     = (lbe_pkg::Y_W'(ql10_r) << 4) + (lbe_pkg::Y_W'(ql10_r) << 3)
            + (lbe_pkg::Y_W'(ql10_r) << 1) + lbe_pkg::Y_W'(ql10_r);
    ry_raw  = y10_r - y27;
    fix_l   = ry_raw >= lbe_pkg::Y_W'(lbe_pkg::DIV_D);
    q11_nxt = (lbe_pkg::Q_W'(qh10_r) << lbe_pkg::SPLIT_W) + lbe_pkg::Q_W'(ql10_r)
            + lbe_pkg::Q_W'(fix_l);
  end

  // valid and tag shift
  always_comb begin
    vld_nxt[0]      = issue;
    tag_nxt[0].dir  = dir_r;
    tag_nxt[0].last = at_last;
    tag_nxt[0].lin  = node_lin_r;
    tag_nxt[0].neg  = 1'b0;
    for (int i = 1; i < N_STG; i++) begin
      vld_nxt[i] = vld_r[i-1];
      tag_nxt[i] = tag_r[i-1];
    end
    tag_nxt[3].neg = t3_r[T_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_STG; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      for (int i = 0; i < N_STG; i++) begin
        vld_r[i] <= vld_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N_STG; i++) begin
        tag_r[i] <= tag_nxt[i];
      end
      s1_r    <= s1_nxt;
      sqx_r   <= sqx_nxt;
      sqy_r   <= sqy_nxt;
      sqz_r   <= sqz_nxt;
      dn1_r   <= dn1_nxt;
      s2_r    <= s1_r;
      ssq2_r  <= ssq2_nxt;
      uu2_r   <= uu2_nxt;
      dn2_r   <= dn1_r;
      t3_r    <= t3_nxt;
      dn3_r   <= dn2_r;
      mag4_r  <= mag4_nxt;
      dn4_r   <= dn3_r;
      for (int j = 0; j < N_CHUNK; j++) begin
        pp5_r[j] <= pp5_nxt[j];
      end
      prod6_r <= prod6_nxt;
      x7_r    <= x7_nxt;
      qh8_r   <= qh8_nxt;
      h8_r    <= x7_r[lbe_pkg::CLAMP_W-1:lbe_pkg::SPLIT_W];
      l8_r    <= x7_r[lbe_pkg::SPLIT_W-1:0];
      qh9_r   <= qh9_nxt;
      y9_r    <= y9_nxt;
      ql10_r  <= ql10_nxt;
      y10_r   <= y9_r;
      qh10_r  <= qh9_r;
      q11_r   <= q11_nxt;
    end
  end

  // output register: sign and saturate
  logic [lbe_pkg::DIR_W-1:0] out_dir_r;
  logic [lbe_pkg::POP_W-1:0] out_pop_r, pop_nxt;
  logic                      out_last_r;

  always_comb begin
    if (tag_r[10].neg) begin
      pop_nxt = (q11_r > lbe_pkg::POP_MIN_MAG) ? lbe_pkg::POP_MIN
                                               : lbe_pkg::POP_W'(0) - q11_r;
    end else begin
      pop_nxt = (q11_r > lbe_pkg::POP_MAX_MAG) ? lbe_pkg::POP_MAX : q11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[10];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dir_r  <= tag_r[10].dir;
      out_pop_r  <= pop_nxt;
      out_last_r <= tag_r[10].last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_direction  = out_dir_r;
  assign out_population = out_pop_r;
  assign out_last       = out_last_r;

  `LBE_ASSERT_IMP(a_accept_on_last, in_valid && !in_stall && busy_r, at_last, "node taken before last direction issued")
  `LBE_ASSERT_NXT(a_issue_keeps_busy, issue && !at_last, busy_r, "sequencer dropped a node early")
  `LBE_ASSERT_IMP(a_div_remainder, vld_r[8], y9_r[lbe_pkg::Y_W-1:lbe_pkg::SPLIT_W] < lbe_pkg::REM_W'(lbe_pkg::DIV_D), "upper quotient digit not corrected")

endmodule
